/* src/sps_pkg.sv */
// shared types, codes and helpers for the solenoid pulse sequencer
`default_nettype none

package sps_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int VALVE_W  = 3;
    localparam int CUR_W    = 16;
    localparam int TIMER_W  = 16;
    localparam int COIL_W   = 6;
    localparam int RES_W    = 16;
    localparam int MEAS_W   = 17;
    localparam int PHASE_W  = 2;

    // configuration port
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // resistance numerator 24 V * 1000, and its quotient width
    localparam int            DIV_STEPS  = 15;
    localparam int            DIV_CNT_W  = 4;
    localparam logic [14:0]   RESIST_NUM = 15'd24000;
    localparam logic [16:0]   ZERO_FLAG  = 17'h10000;
    localparam logic [15:0]   TIMER_MAX  = 16'hFFFF;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_OUT     = 2'd1;
    localparam logic [OP_W-1:0] OP_IN      = 2'd2;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd3;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // measurement phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HELD = 2'd2;

    // register indexes
    localparam logic [1:0] REG_OUT_KEEP = 2'd0;
    localparam logic [1:0] REG_IN_KEEP  = 2'd1;
    localparam logic [1:0] REG_SETTLE   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic latch_req;
        logic start_div;
        logic div_step;
        logic service;
        logic load_report;
        logic load_status;
    } sps_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic done_cur;
    } sps_stat_t;

    // saturating timer increment
    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        return (t == TIMER_MAX) ? t : t + 16'd1;
    endfunction

endpackage

`default_nettype wire

/* src/sps_if.sv */
// handshake channel interfaces for request items and result words
`default_nettype none

interface sps_item_if import sps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALVE_W-1:0] valve;
    logic [CUR_W-1:0]   current_ma;

    modport source (output valid, operation, valve, current_ma, input ready);
    modport sink   (input valid, operation, valve, current_ma, output ready);
endinterface

interface sps_result_if import sps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COIL_W-1:0]  out_coils;
    logic [COIL_W-1:0]  in_coils;
    logic [COIL_W-1:0]  position_bits;
    logic [VALVE_W-1:0] report_valve;
    logic [RES_W-1:0]   resistance_ohm;
    logic               zero_current;
    logic               last;

    modport source (output valid, kind, out_coils, in_coils, position_bits, report_valve,
                    resistance_ohm, zero_current, last, input ready);
    modport sink   (input valid, kind, out_coils, in_coils, position_bits, report_valve,
                    resistance_ohm, zero_current, last, output ready);
endinterface

`default_nettype wire

/* src/sps_controller.sv */
// sequencing state machine: divide, service each valve, emit reports and status
`default_nettype none

module sps_controller import sps_pkg::*; #(
    parameter int NUM_VALVES = 6,
    parameter int IDX_W      = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [OP_W-1:0]  in_op,
    output logic                  in_ready,
    output sps_cmd_t              cmd,
    output logic [IDX_W-1:0]      idx,
    input  wire sps_stat_t        stat
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIVIDE  = 5'b00010,
        ST_SERVICE = 5'b00100,
        ST_EMIT    = 5'b01000,
        ST_STATUS  = 5'b10000
    } ctrl_state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VALVES - 1);

    ctrl_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    assign idx = idx_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_TICK)
                    begin
                        cmd.start_div = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.latch_req = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SERVICE;
                end
            end
            ST_SERVICE:
            begin
                cmd.service = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // one valve per cycle, waiting on the output slot for a report
                if (!stat.done_cur || stat.slot_free)
                begin
                    cmd.load_report = stat.done_cur;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = ST_STATUS;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_STATUS:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* src/sps_datapath.sv */
// per-valve state, serial divider, valve service logic and output word register
`default_nettype none

module sps_datapath import sps_pkg::*; #(
    parameter int NUM_VALVES = 6,
    parameter int IDX_W      = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sps_cmd_t           cmd,
    input  wire logic [IDX_W-1:0]   idx,
    output sps_stat_t               stat,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [VALVE_W-1:0] valve,
    input  wire logic [CUR_W-1:0]   current_ma,
    input  wire logic [TIMER_W-1:0] out_keep,
    input  wire logic [TIMER_W-1:0] in_keep,
    input  wire logic [TIMER_W-1:0] settle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_kind,
    output logic [COIL_W-1:0]       out_oc,
    output logic [COIL_W-1:0]       out_ic,
    output logic [COIL_W-1:0]       out_pos,
    output logic [VALVE_W-1:0]      out_rv,
    output logic [RES_W-1:0]        out_res,
    output logic                    out_zero,
    output logic                    out_last
);

    localparam int PAD_W = (NUM_VALVES > COIL_W) ? NUM_VALVES : COIL_W;

    // per-valve state
    logic [NUM_VALVES-1:0] out_req_reg, in_req_reg, meas_req_reg;
    logic [NUM_VALVES-1:0] out_act_reg, in_act_reg, pos_reg, done_reg;
    logic [TIMER_W-1:0]    ptimer_reg [NUM_VALVES];
    logic [TIMER_W-1:0]    mtimer_reg [NUM_VALVES];
    logic [PHASE_W-1:0]    phase_reg  [NUM_VALVES];
    logic [MEAS_W-1:0]     meas_reg   [NUM_VALVES];

    // divider
    logic [CUR_W-1:0]     cur_reg;
    logic [CUR_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [CUR_W:0]       div_shift;
    logic                 div_ge;
    logic [CUR_W:0]       div_rem;
    logic [MEAS_W-1:0]    div_value;

    // output word register
    logic                 out_valid_reg;
    logic                 out_kind_reg, out_zero_reg, out_last_reg;
    logic [COIL_W-1:0]    out_oc_reg, out_ic_reg, out_pos_reg;
    logic [VALVE_W-1:0]   out_rv_reg;
    logic [RES_W-1:0]     out_res_reg;

    // service results for the selected valve
    logic                 svc_oa, svc_ia, svc_orq, svc_irq, svc_mrq, svc_pos, svc_done;
    logic [TIMER_W-1:0]   svc_pt, svc_mt;
    logic [PHASE_W-1:0]   svc_ph;
    logic [MEAS_W-1:0]    svc_mv;
    logic [TIMER_W:0]     thr_sum;
    logic [TIMER_W-1:0]   thr;

    // snapshot
    logic [NUM_VALVES-1:0] ic_vec;
    logic [PAD_W-1:0]      oc_pad, ic_pad, pos_pad;

    logic                  req_in_range;
    logic [IDX_W-1:0]      req_idx;

    assign req_in_range = (32'(valve) < NUM_VALVES);
    assign req_idx      = IDX_W'(valve);

    // restoring division step
    assign div_shift = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign div_ge    = (div_shift >= {1'b0, cur_reg});
    assign div_rem   = div_ge ? (div_shift - {1'b0, cur_reg}) : div_shift;
    assign div_value = (cur_reg == '0) ? ZERO_FLAG : {1'b0, RES_W'(quo_reg)};

    // measurement wait threshold, clamped
    assign thr_sum = {1'b0, in_keep} + {1'b0, settle};
    assign thr     = thr_sum[TIMER_W] ? TIMER_MAX : thr_sum[TIMER_W-1:0];

    // timer advance and servicing for one valve
    always_comb
    begin
        svc_oa   = out_act_reg[idx];
        svc_ia   = in_act_reg[idx];
        svc_orq  = out_req_reg[idx];
        svc_irq  = in_req_reg[idx];
        svc_mrq  = meas_req_reg[idx];
        svc_pos  = pos_reg[idx];
        svc_pt   = ptimer_reg[idx];
        svc_mt   = mtimer_reg[idx];
        svc_ph   = phase_reg[idx];
        svc_mv   = meas_reg[idx];
        svc_done = 1'b0;

        if (svc_oa || svc_ia)
        begin
            svc_pt = sat_inc(svc_pt);
        end
        if (svc_ph == PH_WAIT)
        begin
            svc_mt = sat_inc(svc_mt);
        end

        // out pulse
        if (svc_orq)
        begin
            if (!svc_oa && !svc_ia)
            begin
                svc_oa  = 1'b1;
                svc_pt  = '0;
                svc_pos = 1'b1;
            end
            else if (svc_oa && (svc_pt >= out_keep))
            begin
                svc_oa  = 1'b0;
                svc_pt  = '0;
                svc_orq = 1'b0;
            end
        end

        // in pulse
        if (svc_irq)
        begin
            if (!svc_oa && !svc_ia)
            begin
                svc_ia  = 1'b1;
                svc_pt  = '0;
                svc_pos = 1'b0;
            end
            else if (svc_ia && (svc_pt >= in_keep))
            begin
                svc_ia  = 1'b0;
                svc_pt  = '0;
                svc_irq = 1'b0;
            end
        end

        // resistance measurement
        if (svc_mrq)
        begin
            case (svc_ph)
                PH_IDLE:
                begin
                    svc_ph = PH_WAIT;
                    svc_mt = '0;
                end
                PH_WAIT:
                begin
                    if (svc_mt >= thr)
                    begin
                        svc_mv = div_value;
                        svc_ph = PH_HELD;
                    end
                end
                default:
                begin
                    svc_ph   = PH_IDLE;
                    svc_mrq  = 1'b0;
                    svc_mt   = '0;
                    svc_done = 1'b1;
                end
            endcase
        end
    end

    // coil snapshot, padded to the output width
    always_comb
    begin
        for (int i = 0; i < NUM_VALVES; i++)
        begin
            ic_vec[i] = in_act_reg[i] || (phase_reg[i] != PH_IDLE);
        end
    end

    assign oc_pad  = PAD_W'(out_act_reg);
    assign ic_pad  = PAD_W'(ic_vec);
    assign pos_pad = PAD_W'(pos_reg);

    // valve state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_req_reg  <= '0;
            in_req_reg   <= '0;
            meas_req_reg <= '0;
            out_act_reg  <= '0;
            in_act_reg   <= '0;
            pos_reg      <= '0;
            done_reg     <= '0;
            for (int i = 0; i < NUM_VALVES; i++)
            begin
                ptimer_reg[i] <= '0;
                mtimer_reg[i] <= '0;
                phase_reg[i]  <= PH_IDLE;
                meas_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.latch_req && req_in_range)
            begin
                case (operation)
                    OP_OUT:     out_req_reg[req_idx]  <= 1'b1;
                    OP_IN:      in_req_reg[req_idx]   <= 1'b1;
                    OP_MEASURE: meas_req_reg[req_idx] <= 1'b1;
                    default:    ;
                endcase
            end
            if (cmd.service)
            begin
                out_req_reg[idx]  <= svc_orq;
                in_req_reg[idx]   <= svc_irq;
                meas_req_reg[idx] <= svc_mrq;
                out_act_reg[idx]  <= svc_oa;
                in_act_reg[idx]   <= svc_ia;
                pos_reg[idx]      <= svc_pos;
                done_reg[idx]     <= svc_done;
                ptimer_reg[idx]   <= svc_pt;
                mtimer_reg[idx]   <= svc_mt;
                phase_reg[idx]    <= svc_ph;
                meas_reg[idx]     <= svc_mv;
            end
        end
    end

    // divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            cur_reg <= current_ma;
            rem_reg <= '0;
            quo_reg <= RESIST_NUM;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_rem[CUR_W-1:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], div_ge};
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_report || cmd.load_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_report || cmd.load_status)
        begin
            out_oc_reg  <= oc_pad[COIL_W-1:0];
            out_ic_reg  <= ic_pad[COIL_W-1:0];
            out_pos_reg <= pos_pad[COIL_W-1:0];
            if (cmd.load_report)
            begin
                out_kind_reg <= KIND_REPORT;
                out_rv_reg   <= VALVE_W'(idx);
                out_res_reg  <= meas_reg[idx][RES_W-1:0];
                out_zero_reg <= meas_reg[idx][MEAS_W-1];
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_kind_reg <= KIND_STATUS;
                out_rv_reg   <= '0;
                out_res_reg  <= '0;
                out_zero_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.done_cur  = done_reg[idx];

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_oc    = out_oc_reg;
    assign out_ic    = out_ic_reg;
    assign out_pos   = out_pos_reg;
    assign out_rv    = out_rv_reg;
    assign out_res   = out_res_reg;
    assign out_zero  = out_zero_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* src/solenoid_pulse_sequencer_top.sv */
// top level: configuration registers, controller and datapath of the valve sequencer
// request items (out, in, measure) are latched while idle and give no word
// a tick is accepted, runs the serial divider, services each valve in turn, scans each
// valve for a report, waiting on the output slot, and ends with the status word
// reports come in valve order, the status word last
// rst_n clears all valve state and loads the keep/settle registers with 15, 15, 10
`default_nettype none

module solenoid_pulse_sequencer_top import sps_pkg::*; #(
    parameter int NUM_VALVES = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    sps_item_if.sink               item,
    sps_result_if.source           result
);

    localparam int IDX_W = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;

    logic [TIMER_W-1:0] out_keep_reg, in_keep_reg, settle_reg;
    logic               cfg_write;
    logic [1:0]         cfg_sel;
    sps_cmd_t           cmd;
    sps_stat_t          stat;
    logic [IDX_W-1:0]   idx;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_keep_reg <= 16'd15;
            in_keep_reg  <= 16'd15;
            settle_reg   <= 16'd10;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_OUT_KEEP: out_keep_reg <= pwdata[TIMER_W-1:0];
                REG_IN_KEEP:  in_keep_reg  <= pwdata[TIMER_W-1:0];
                REG_SETTLE:   settle_reg   <= pwdata[TIMER_W-1:0];
                default:      ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_sel)
            REG_OUT_KEEP: prdata = APB_DW'(out_keep_reg);
            REG_IN_KEEP:  prdata = APB_DW'(in_keep_reg);
            REG_SETTLE:   prdata = APB_DW'(settle_reg);
            default:      prdata = '0;
        endcase
    end

    // sequencing
    sps_controller #(
        .NUM_VALVES (NUM_VALVES),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.operation),
        .in_ready (item.ready),
        .cmd      (cmd),
        .idx      (idx),
        .stat     (stat)
    );

    // valve state and output word
    sps_datapath #(
        .NUM_VALVES (NUM_VALVES),
        .IDX_W      (IDX_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .idx        (idx),
        .stat       (stat),
        .operation  (item.operation),
        .valve      (item.valve),
        .current_ma (item.current_ma),
        .out_keep   (out_keep_reg),
        .in_keep    (in_keep_reg),
        .settle     (settle_reg),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_kind   (result.kind),
        .out_oc     (result.out_coils),
        .out_ic     (result.in_coils),
        .out_pos    (result.position_bits),
        .out_rv     (result.report_valve),
        .out_res    (result.resistance_ohm),
        .out_zero   (result.zero_current),
        .out_last   (result.last)
    );

    // a report is never the closing word of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == KIND_REPORT)) |-> !result.last)
        else $error("report word marked last");

    // a zero-current report carries zero resistance
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_current) |-> (result.resistance_ohm == '0))
        else $error("zero current with nonzero resistance");

    // a tick keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.operation == OP_TICK)) |=> !item.ready)
        else $error("new item taken while a tick is in progress");

    // commands stay mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch_req, cmd.start_div, cmd.div_step, cmd.service,
                  cmd.load_report, cmd.load_status}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

/* bench/solenoid_pulse_sequencer_top_test.sv */
// self-checking testbench for the solenoid pulse sequencer top level
`timescale 1ns / 100ps

module solenoid_pulse_sequencer_top_test;
    import sps_pkg::*;

    localparam int      CLK_PERIOD       = 10;
    localparam int      NUM_VALVES       = 6;
    localparam int      DRAIN_CYCLES     = 2 * NUM_VALVES + 17 + 20;
    localparam int      LONG_HOLD        = 400;
    localparam int      RESIST_NUMERATOR = 24000;
    localparam longint  TIMEOUT_NS       = 64'd3_000_000;

    // one result word, field for field
    typedef struct packed {
        logic               kind;
        logic [COIL_W-1:0]  out_coils;
        logic [COIL_W-1:0]  in_coils;
        logic [COIL_W-1:0]  position_bits;
        logic [VALVE_W-1:0] report_valve;
        logic [RES_W-1:0]   resistance_ohm;
        logic               zero_current;
        logic               last;
    } valve_word_t;

    // one row of the directed table
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALVE_W-1:0] valve;
        logic [CUR_W-1:0]   cur;
        bit                 typed;
        valve_word_t        word;
    } step_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sps_item_if   item_ch ();
    sps_result_if result_ch ();

    solenoid_pulse_sequencer_top #(
        .NUM_VALVES (NUM_VALVES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // predictor state: pending requests, running pulses and measurements
    bit [15:0] cfg_out_keep = 16'd15;
    bit [15:0] cfg_in_keep  = 16'd15;
    bit [15:0] cfg_settle   = 16'd10;

    bit                 want_out   [NUM_VALVES];
    bit                 want_in    [NUM_VALVES];
    bit                 want_meas  [NUM_VALVES];
    bit                 on_out     [NUM_VALVES];
    bit                 on_in      [NUM_VALVES];
    bit [TIMER_W-1:0]   pulse_count[NUM_VALVES];
    bit [PHASE_W-1:0]   meas_phase [NUM_VALVES];
    bit [TIMER_W-1:0]   meas_count [NUM_VALVES];
    bit [MEAS_W-1:0]    meas_result[NUM_VALVES];
    bit [COIL_W-1:0]    pos_bits;

    valve_word_t pending_words[$];
    valve_word_t fresh_words[$];
    step_row_t   steps[$];
    int          errors = 0;
    bit          hold_wanted = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // saturating tick counter
    function automatic bit [TIMER_W-1:0] bump(input bit [TIMER_W-1:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // coil drive status word as it stands after a tick
    function automatic valve_word_t status_word(input logic [COIL_W-1:0] oc,
                                                input logic [COIL_W-1:0] ic,
                                                input logic [COIL_W-1:0] pos);
        return {KIND_STATUS, oc, ic, pos, 3'd0, 16'd0, 1'b0, 1'b1};
    endfunction

    // latch a request, or run one tick and collect the words it gives
    task automatic step_valves(input logic [OP_W-1:0] op, input logic [VALVE_W-1:0] valve,
                               input logic [CUR_W-1:0] cur);
        bit [16:0]        sum;
        bit [TIMER_W-1:0] wait_lim;
        bit [COIL_W-1:0]  oc;
        bit [COIL_W-1:0]  ic;
        bit               ended[NUM_VALVES];
        valve_word_t      w;
        fresh_words.delete();
        if (op != OP_TICK)
        begin
            if (valve < NUM_VALVES)
            begin
                case (op)
                    OP_OUT:  want_out[valve]  = 1'b1;
                    OP_IN:   want_in[valve]   = 1'b1;
                    default: want_meas[valve] = 1'b1;
                endcase
            end
        end
        else
        begin
            // timers first
            for (int v = 0; v < NUM_VALVES; v++)
            begin
                if (on_out[v] || on_in[v])
                    pulse_count[v] = bump(pulse_count[v]);
                if (meas_phase[v] == PH_WAIT)
                    meas_count[v] = bump(meas_count[v]);
            end
            sum = {1'b0, cfg_in_keep} + {1'b0, cfg_settle};
            wait_lim = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
            // service in valve order: out, in, measurement
            for (int v = 0; v < NUM_VALVES; v++)
            begin
                ended[v] = 1'b0;
                if (want_out[v])
                begin
                    if (!on_out[v] && !on_in[v])
                    begin
                        on_out[v] = 1'b1;
                        pulse_count[v] = '0;
                        pos_bits[v] = 1'b1;
                    end
                    else if (on_out[v] && pulse_count[v] >= cfg_out_keep)
                    begin
                        on_out[v] = 1'b0;
                        pulse_count[v] = '0;
                        want_out[v] = 1'b0;
                    end
                end
                if (want_in[v])
                begin
                    if (!on_out[v] && !on_in[v])
                    begin
                        on_in[v] = 1'b1;
                        pulse_count[v] = '0;
                        pos_bits[v] = 1'b0;
                    end
                    else if (on_in[v] && pulse_count[v] >= cfg_in_keep)
                    begin
                        on_in[v] = 1'b0;
                        pulse_count[v] = '0;
                        want_in[v] = 1'b0;
                    end
                end
                if (want_meas[v])
                begin
                    if (meas_phase[v] == PH_IDLE)
                    begin
                        meas_phase[v] = PH_WAIT;
                        meas_count[v] = '0;
                    end
                    else if (meas_phase[v] == PH_WAIT)
                    begin
                        if (meas_count[v] >= wait_lim)
                        begin
                            if (cur == 0)
                                meas_result[v] = 17'h10000;
                            else
                                meas_result[v] = {1'b0, 16'(RESIST_NUMERATOR / cur)};
                            meas_phase[v] = PH_HELD;
                        end
                    end
                    else
                    begin
                        meas_phase[v] = PH_IDLE;
                        want_meas[v] = 1'b0;
                        meas_count[v] = '0;
                        ended[v] = 1'b1;
                    end
                end
            end
            // coil snapshot
            oc = '0;
            ic = '0;
            for (int v = 0; v < NUM_VALVES; v++)
            begin
                oc[v] = on_out[v];
                ic[v] = on_in[v] || (meas_phase[v] != PH_IDLE);
            end
            // reports in valve order, status last
            for (int v = 0; v < NUM_VALVES; v++)
            begin
                if (ended[v])
                begin
                    w = {KIND_REPORT, oc, ic, pos_bits, 3'(v), meas_result[v][15:0],
                         meas_result[v][16], 1'b0};
                    fresh_words.push_back(w);
                end
            end
            fresh_words.push_back(status_word(oc, ic, pos_bits));
        end
    endtask

    // offer one item, wait for it to be taken, then record what it should give
    task automatic push_item(input logic [OP_W-1:0] op, input logic [VALVE_W-1:0] valve,
                             input logic [CUR_W-1:0] cur, input bit typed,
                             input valve_word_t typed_word);
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.valve      <= valve;
        item_ch.current_ma <= cur;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        step_valves(op, valve, cur);
        if (typed)
            pending_words.push_back(typed_word);
        else
            foreach (fresh_words[i])
                pending_words.push_back(fresh_words[i]);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending and let every expected word come home
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input bit [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OUT_KEEP: cfg_out_keep = value;
            REG_IN_KEEP:  cfg_in_keep  = value;
            default:      cfg_settle   = value;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] idx, input bit [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== {16'd0, want})
        begin
            errors++;
            $display("%0t: register %0d expected %0d got %0d", $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input bit [15:0] out_keep, input bit [15:0] in_keep,
                              input bit [15:0] settle);
        write_reg(REG_OUT_KEEP, out_keep);
        write_reg(REG_IN_KEEP, in_keep);
        write_reg(REG_SETTLE, settle);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [VALVE_W-1:0] valve,
                           input logic [CUR_W-1:0] cur, input bit typed,
                           input valve_word_t word);
        step_row_t r;
        r.op    = op;
        r.valve = valve;
        r.cur   = cur;
        r.typed = typed;
        r.word  = word;
        steps.push_back(r);
    endtask

    // random items sent in bursts; a pause for a full drain at pause_at
    task automatic run_random(input int count, input int pause_at);
        int               r;
        int               burst_left;
        logic [OP_W-1:0]  op;
        logic [VALVE_W-1:0] valve;
        logic [CUR_W-1:0] cur;
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                op = OP_TICK;
            else if (r < 68)
                op = OP_OUT;
            else if (r < 86)
                op = OP_IN;
            else
                op = OP_MEASURE;
            if ($urandom_range(0, 19) == 0)
                valve = 3'($urandom_range(6, 7));
            else
                valve = 3'($urandom_range(0, NUM_VALVES - 1));
            r = $urandom_range(0, 9);
            if (r == 0)
                cur = '0;
            else if (r == 1)
                cur = 16'hFFFF;
            else if (r < 6)
                cur = 16'($urandom_range(1, 300));
            else
                cur = 16'($urandom_range(0, 65535));
            push_item(op, valve, cur, 1'b0, '0);
            if (n == pause_at)
                drain();
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 7) == 0)
                    idle_for($urandom_range(20, 40));
                else
                    idle_for($urandom_range(0, 4));
            end
        end
    endtask

    // result side: stall patterns, plus one long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit hold_taken;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 9) > 2);
                    2:       result_ch.ready <= mode_left[0];
                    default: result_ch.ready <= (mode_left[1:0] == 2'd0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // compare every accepted word with the oldest expectation
    always @(posedge clk)
    begin : watch
        valve_word_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none got kind %0d", $time,
                         result_ch.kind);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("kind", want.kind, result_ch.kind);
                check_field("out_coils", want.out_coils, result_ch.out_coils);
                check_field("in_coils", want.in_coils, result_ch.in_coils);
                check_field("position_bits", want.position_bits, result_ch.position_bits);
                check_field("report_valve", want.report_valve, result_ch.report_valve);
                check_field("resistance_ohm", want.resistance_ohm, result_ch.resistance_ohm);
                check_field("zero_current", want.zero_current, result_ch.zero_current);
                check_field("last", want.last, result_ch.last);
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_TICK;
        item_ch.valve      <= '0;
        item_ch.current_ma <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        check_reg(REG_OUT_KEEP, 16'd15);
        check_reg(REG_IN_KEEP, 16'd15);
        check_reg(REG_SETTLE, 16'd10);

        // directed part with the shortest keep and settle times
        set_config(16'd0, 16'd0, 16'd0);
        add_row(OP_TICK,    3'd0, 16'd0,     1'b1, status_word(6'h00, 6'h00, 6'h00));
        add_row(OP_OUT,     3'd0, 16'd0,     1'b0, '0);
        add_row(OP_OUT,     3'd0, 16'd0,     1'b0, '0);
        add_row(OP_IN,      3'd5, 16'd0,     1'b0, '0);
        add_row(OP_MEASURE, 3'd5, 16'd0,     1'b0, '0);
        // valves past the last one are ignored
        add_row(OP_OUT,     3'd6, 16'd0,     1'b0, '0);
        add_row(OP_MEASURE, 3'd7, 16'd0,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd0,     1'b1, status_word(6'h01, 6'h20, 6'h01));
        // zero current sampled here
        add_row(OP_TICK,    3'd0, 16'd0,     1'b1, status_word(6'h00, 6'h20, 6'h01));
        add_row(OP_TICK,    3'd0, 16'd500,   1'b0, '0);
        // smallest nonzero current
        add_row(OP_MEASURE, 3'd0, 16'd0,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd100,   1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd1,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd1,     1'b0, '0);
        // largest current, two reports from one tick
        add_row(OP_MEASURE, 3'd1, 16'd0,     1'b0, '0);
        add_row(OP_MEASURE, 3'd4, 16'd0,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd0,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'hFFFF,  1'b0, '0);
        add_row(OP_TICK,    3'd7, 16'hFFFF,  1'b0, '0);
        // in and out pending on one valve: out goes first
        add_row(OP_IN,      3'd0, 16'hFFFF,  1'b0, '0);
        add_row(OP_OUT,     3'd0, 16'hFFFF,  1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd2,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd3,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd4,     1'b0, '0);
        add_row(OP_TICK,    3'd0, 16'd5,     1'b0, '0);
        foreach (steps[i])
        begin
            push_item(steps[i].op, steps[i].valve, steps[i].cur, steps[i].typed,
                      steps[i].word);
            if (i % 3 == 2)
                idle_for($urandom_range(0, 3));
        end
        drain();

        // reset-like timing, with one long stall on the result side
        set_config(16'd15, 16'd15, 16'd10);
        hold_wanted = 1'b1;
        run_random(70, -1);
        drain();

        // short random timing, with a full drain halfway
        set_config(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                   16'($urandom_range(0, 5)));
        run_random(90, 45);
        drain();

        // longest times: nothing gets released, the wait limit clamps
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(30, -1);
        drain();

        // short times again, so the long pulses get released
        set_config(16'($urandom_range(1, 3)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(0, 3)));
        run_random(60, -1);
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
